[sv/sem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel gradient magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  localparam int ChanW  = 8;          // bits per color channel
  localparam int PixW   = 3 * ChanW;  // packed RGB, red in the top byte
  localparam int RegW   = 11;         // configuration register width
  localparam int NLanes = 3;

  localparam logic [RegW-1:0] RstImgSize = 11'd1024;

  // configuration register indexes
  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  // item kinds on the input tuser
  localparam logic ReqPixel = 1'b0;
  localparam logic ReqFlush = 1'b1;

  // lane sequencer steps: gradient, square, sum, then 8 root bits, then hold
  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhSquare   = 4'd1;
  localparam logic [3:0] PhSum      = 4'd2;
  localparam logic [3:0] PhRootLast = 4'd10;
  localparam logic [3:0] PhDone     = 4'd11;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ADV,
    S_CALC
  } state_e;

  typedef logic [8:0][ChanW-1:0] win_t;  // 3x3 channel window, row major

  typedef struct packed {
    logic             done;
    logic [ChanW-1:0] mag;
  } lane_res_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } out_flags_t;

endpackage

[sv/sem_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_lane
// One color channel: Sobel gradients, squares, sum and a bitwise root search.
// ----------------------------------------------------------------------------
module sem_lane import sem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  win_t      win_i,
  input  logic      ack_i,
  output lane_res_t res_o
);

  logic [3:0]        ph_q, ph_d;
  logic signed [10:0] gx_q, gy_q, gx_d, gy_d;
  logic [19:0]       sqx_q, sqy_q;
  logic [20:0]       sum_q;
  logic [ChanW-1:0]  root_q, root_d;
  logic signed [21:0] px, py;
  logic [10:0]       xp, xn, yp, yn;
  logic [2:0]        bitpos;
  logic [ChanW-1:0]  trial, trial_m1;
  logic [15:0]       tprod;

  always_comb begin
    xp = 11'(win_i[2]) + 11'({win_i[5], 1'b0}) + 11'(win_i[8]);
    xn = 11'(win_i[0]) + 11'({win_i[3], 1'b0}) + 11'(win_i[6]);
    yp = 11'(win_i[6]) + 11'({win_i[7], 1'b0}) + 11'(win_i[8]);
    yn = 11'(win_i[0]) + 11'({win_i[1], 1'b0}) + 11'(win_i[2]);
    gx_d = signed'(xp) - signed'(xn);
    gy_d = signed'(yp) - signed'(yn);
    px = gx_q * gx_q;
    py = gy_q * gy_q;
    // root bits are decided from the top down
    bitpos   = 3'(PhRootLast - ph_q);
    trial    = root_q | ChanW'(1 << bitpos);
    trial_m1 = trial - ChanW'(1);
    tprod    = trial * trial_m1;
    root_d   = root_q;
    if (21'(tprod) < sum_q) root_d = trial;
  end

  always_comb begin
    ph_d = ph_q;
    if (ph_q == PhIdle) begin
      if (start_i) ph_d = PhSquare;
    end else if (ph_q == PhDone) begin
      if (ack_i) ph_d = PhIdle;
    end else begin
      ph_d = ph_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PhIdle && start_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (ph_q == PhSquare) begin
      sqx_q <= 20'(px);
      sqy_q <= 20'(py);
    end
    if (ph_q == PhSum) begin
      sum_q  <= 21'(sqx_q) + 21'(sqy_q);
      root_q <= '0;
    end else if (ph_q > PhSum && ph_q <= PhRootLast) begin
      root_q <= root_d;
    end
  end

  assign res_o.done = (ph_q == PhDone);
  assign res_o.mag  = root_q;

endmodule

[sv/sem_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_merge
// Joins the three lane results and the position flags into the output register.
// ----------------------------------------------------------------------------
module sem_merge import sem_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_res_t [NLanes-1:0] lane_i,
  input  out_flags_t             flags_i,
  output logic                   load_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [31:0]            m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  logic            vld_q;
  logic [PixW-1:0] rgb_q;
  out_flags_t      flg_q;

  assign load_o = lane_i[0].done && lane_i[1].done && lane_i[2].done
                  && (!vld_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      rgb_q <= {lane_i[2].mag, lane_i[1].mag, lane_i[0].mag};
      flg_q <= flags_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {7'd0, flg_q.row_end, rgb_q};
  assign m_axis_tlast_o  = flg_q.frame_end;

endmodule

[sv/sobel_edge_magnitude_rgb_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// Streaming 3x3 Sobel gradient magnitude on RGB pixels, three channel lanes.
// ----------------------------------------------------------------------------
// Throughput: an item is taken only while the sequencer is idle, so a new item
//   waits until the last one has stepped and, if it yields a result, until the
//   lane root search (8 steps after gradient, square, sum) is through and the
//   result is loaded into the output register. Dropped or ignored items take
//   no step. A flush item may step up to two raster positions.
// Reset: control, counters and window clear at once; the line memory is not
//   cleared, its unwritten entries only feed masked window positions.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MaxWidth  = DefMaxWidth,
  parameter int MaxHeight = DefMaxHeight
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration writes
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [RegW-1:0] cfg_data_i,
  // input items
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [23:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic            s_axis_tuser_i,   // req_type
  // result items
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [31:0]     m_axis_tdata_o,   // red_out, green_out, blue_out, row_end
  output logic            m_axis_tlast_o    // frame_end
);

  localparam int IW  = $clog2(MaxWidth);        // column counter
  localparam int RW  = $clog2(MaxHeight + 2);   // row counter, runs past last row in flush
  localparam int WW  = $clog2(MaxWidth + 1);
  localparam int CW0 = (RegW > WW) ? RegW : WW;
  localparam int CW1 = (CW0 > RW) ? CW0 : RW;
  localparam int CW  = CW1 + 1;                 // common compare width

  state_e state_q, state_d;

  logic [RegW-1:0] width_q, height_q;
  logic [IW-1:0]   ic_q;
  logic [RW-1:0]   ir_q;
  logic            flush_q;
  logic [PixW-1:0] pix_q;
  logic [PixW-1:0] win_q [3][2];   // last two window columns, rows top to bottom
  logic [2*PixW-1:0] rd_q;         // {upper row, middle row} at ic_q
  logic [2*PixW-1:0] line_mem [MaxWidth];

  // effective geometry and raster position, all at the common width
  logic [CW-1:0] wreg, hreg, weff, heff, icx, irx, rx, cx, icn;
  logic          in_acc, emit, top_z, bot_z, lft_z, rgt_z, row_end, fend, adv;
  logic [PixW-1:0] col [3];
  logic [PixW-1:0] view [3][3];
  win_t [NLanes-1:0] lane_win;
  lane_res_t [NLanes-1:0] lane_res;
  out_flags_t flags_q;
  logic lane_start, load;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign adv             = (state_q == S_ADV);

  always_comb begin
    wreg = CW'(width_q);
    hreg = CW'(height_q);
    weff = (wreg == '0) ? CW'(1) : ((wreg > CW'(MaxWidth)) ? CW'(MaxWidth) : wreg);
    heff = (hreg == '0) ? CW'(1) : ((hreg > CW'(MaxHeight)) ? CW'(MaxHeight) : hreg);
    icx  = CW'(ic_q);
    irx  = CW'(ir_q);
    // result position trails the input by one row and one column
    emit = (irx >= CW'(2)) || (irx == CW'(1) && icx >= CW'(1));
    rx   = (icx == '0) ? irx - CW'(2) : irx - CW'(1);
    cx   = (icx == '0) ? weff - CW'(1) : icx - CW'(1);
    top_z   = (rx < CW'(1));
    bot_z   = (rx + CW'(1) >= heff);
    lft_z   = (cx < CW'(1));
    rgt_z   = (cx + CW'(1) >= weff);
    row_end = (cx == weff - CW'(1));
    fend    = row_end && (rx == heff - CW'(1));
    icn     = icx + CW'(1);
  end

  // window view with the edges outside the image forced to zero
  always_comb begin
    col[0] = rd_q[2*PixW-1:PixW];
    col[1] = rd_q[PixW-1:0];
    col[2] = pix_q;
    for (int i = 0; i < 3; i++) begin
      view[i][0] = win_q[i][0];
      view[i][1] = win_q[i][1];
      view[i][2] = (icx == '0) ? '0 : col[i];
      if (lft_z) view[i][0] = '0;
      if (rgt_z) view[i][2] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      if (top_z) view[0][j] = '0;
      if (bot_z) view[2][j] = '0;
    end
    for (int k = 0; k < NLanes; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lane_win[k][i*3+j] = view[i][j][PixW-1-k*ChanW -: ChanW];
        end
      end
    end
  end

  assign lane_start = adv && emit;

  // sequencer: accept, step one raster position (a flush steps on until a result is due), then wait for the lanes
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == ReqPixel && CW'(ir_q) < heff) state_d = S_ADV;
          if (s_axis_tuser_i == ReqFlush && CW'(ir_q) >= heff) state_d = S_ADV;
        end
      end
      S_READ: state_d = S_ADV;
      S_ADV: begin
        if (emit) state_d = S_CALC;
        else if (flush_q) state_d = S_READ;
        else state_d = S_IDLE;
      end
      S_CALC: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= RstImgSize;
      height_q <= RstImgSize;
      ic_q     <= '0;
      ir_q     <= '0;
      flush_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // any write restarts the frame
        if (cfg_idx_i == CfgIdxWidth) width_q <= cfg_data_i;
        if (cfg_idx_i == CfgIdxHeight) height_q <= cfg_data_i;
        ic_q <= '0;
        ir_q <= '0;
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= '0;
          win_q[i][1] <= '0;
        end
      end else if (adv) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= col[i];
        end
        if (emit && fend) begin
          ic_q <= '0;
          ir_q <= '0;
        end else if (icn >= weff) begin
          ic_q <= '0;
          ir_q <= RW'(irx + CW'(1));
        end else begin
          ic_q <= IW'(icn);
        end
      end
      if (in_acc) flush_q <= (s_axis_tuser_i == ReqFlush);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      // tdata carries red in the low byte; the window keeps red on top
      pix_q <= (s_axis_tuser_i == ReqFlush) ? '0 :
               {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]};
    end
    if (lane_start) begin
      flags_q.row_end   <= row_end;
      flags_q.frame_end <= fend;
    end
  end

  // line memory: upper row and middle row side by side, one port each way
  always_ff @(posedge clk_i) begin
    if (adv) line_mem[ic_q] <= {rd_q[PixW-1:0], pix_q};
    rd_q <= line_mem[ic_q];
  end

  for (genvar g = 0; g < NLanes; g++) begin : g_lane
    sem_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .win_i   (lane_win[g]),
      .ack_i   (load),
      .res_o   (lane_res[g])
    );
  end

  sem_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .lane_i          (lane_res),
    .flags_i         (flags_q),
    .load_o          (load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
